/* rtl/hck_pkg.sv */
// Shared types and constants for the HSV chroma key compositor.
// No dependencies; imported by hsv_chroma_key_compositor.
package hck_pkg;

  // Fixed-point scaling used by the HSV conversion
  localparam int unsigned FracBits = 12;
  localparam int unsigned SatNum   = 255 << FracBits;       // S = d * round(SatNum / mx)
  localparam int unsigned HueNum   = 30 << FracBits;        // H = h0 * round(HueNum / d)
  localparam int unsigned SdWidth  = 20;
  localparam int unsigned HdWidth  = 17;
  localparam int unsigned HueWrap  = 180;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_HUE_LOW  = 3'd0,
    CFG_HUE_HIGH = 3'd1,
    CFG_SAT_LOW  = 3'd2,
    CFG_SAT_HIGH = 3'd3,
    CFG_VAL_LOW  = 3'd4,
    CFG_VAL_HIGH = 3'd5
  } cfg_idx_e;

  // Reset values of the key bands
  localparam logic [7:0] HueLowRst  = 8'd65;
  localparam logic [7:0] HueHighRst = 8'd75;
  localparam logic [7:0] SatLowRst  = 8'd0;
  localparam logic [7:0] SatHighRst = 8'd255;
  localparam logic [7:0] ValLowRst  = 8'd0;
  localparam logic [7:0] ValHighRst = 8'd255;

  // One BGR pixel
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

endpackage

/* rtl/hsv_chroma_key_compositor.sv */
// Per-pixel HSV chroma key: converts the foreground to HSV, keys it against
// six band registers and substitutes the background. Depends on hck_pkg.
//
// Channel  Direction  Signals                                    Handshake
// in       input      fg_blue/green/red_i, bg_blue/green/red_i   in_valid_i / in_ready_o
// out      output     out_blue/green/red_o, key_hit_o            out_valid_o / out_ready_i
// cfg      input      cfg_idx_i, cfg_data_i                      cfg_we_i (no wait)
//
// Four register stages: min/max and raw hue, reciprocal table lookup,
// multiply, then round, hue wrap, band compare and output select.
// One pixel per clock sustained while the output register is empty or taken.
// All stages advance together while the output register is empty or taken;
// a held output stalls the whole pipe, which then refuses input.
// Reset clears the valid bits and loads the band registers with their defaults.
module hsv_chroma_key_compositor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] fg_blue_i,
  input  logic [7:0] fg_green_i,
  input  logic [7:0] fg_red_i,
  input  logic [7:0] bg_blue_i,
  input  logic [7:0] bg_green_i,
  input  logic [7:0] bg_red_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_red_o,
  output logic       key_hit_o
);
  import hck_pkg::*;

  // Band registers
  logic [7:0] hue_low_q, hue_high_q, sat_low_q, sat_high_q, val_low_q, val_high_q;

  // Pipeline control
  logic advance;
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;

  // Stage payloads
  pixel_t s1_fg_q, s1_bg_q, s2_fg_q, s2_bg_q, s3_fg_q, s3_bg_q;
  logic [7:0]         s1_mx_q, s1_d_q, s2_mx_q, s2_d_q, s3_mx_q;
  logic signed [11:0] s1_h0_q, s2_h0_q;
  logic [SdWidth-1:0] s2_sd_q;
  logic [HdWidth-1:0] s2_hd_q;
  logic [27:0]        s3_sprod_q;
  logic signed [29:0] s3_hprod_q;
  pixel_t             out_pix_q;
  logic               key_hit_q;

  // Stage 1 combinational
  logic [7:0]         mx_d, mn_d, d_d;
  logic signed [11:0] h0_d;

  // Stage 2 and 3 combinational
  logic [SdWidth-1:0] sd_tab [256];
  logic [HdWidth-1:0] hd_tab [256];
  logic [27:0]        sprod_d;
  logic signed [29:0] hprod_d;

  // Stage 4 combinational
  logic [27:0]        s_round;
  logic [15:0]        sat_val;
  logic signed [29:0] h_round, h_shift, h_wrap;
  logic [8:0]         hue_val;
  logic               hit_d;
  pixel_t             fg_in, bg_in, out_pix_d;

  assign fg_in = '{blue: fg_blue_i, green: fg_green_i, red: fg_red_i};
  assign bg_in = '{blue: bg_blue_i, green: bg_green_i, red: bg_red_i};

  // Write band registers; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= HueLowRst;
      hue_high_q <= HueHighRst;
      sat_low_q  <= SatLowRst;
      sat_high_q <= SatHighRst;
      val_low_q  <= ValLowRst;
      val_high_q <= ValHighRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HUE_LOW:  hue_low_q  <= cfg_data_i;
        CFG_HUE_HIGH: hue_high_q <= cfg_data_i;
        CFG_SAT_LOW:  sat_low_q  <= cfg_data_i;
        CFG_SAT_HIGH: sat_high_q <= cfg_data_i;
        CFG_VAL_LOW:  val_low_q  <= cfg_data_i;
        CFG_VAL_HIGH: val_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance all stages unless a finished result is held
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // Stage 1: max, min, spread and raw hue by sector
  always_comb begin
    mx_d = fg_blue_i;
    mn_d = fg_blue_i;
    if (fg_green_i > mx_d) mx_d = fg_green_i;
    if (fg_red_i > mx_d)   mx_d = fg_red_i;
    if (fg_green_i < mn_d) mn_d = fg_green_i;
    if (fg_red_i < mn_d)   mn_d = fg_red_i;
    d_d = mx_d - mn_d;
    if (mx_d == fg_red_i) begin
      h0_d = $signed({4'b0, fg_green_i}) - $signed({4'b0, fg_blue_i});
    end else if (mx_d == fg_green_i) begin
      h0_d = $signed({4'b0, fg_blue_i}) - $signed({4'b0, fg_red_i})
           + $signed({3'b0, d_d, 1'b0});
    end else begin
      h0_d = $signed({4'b0, fg_red_i}) - $signed({4'b0, fg_green_i})
           + $signed({2'b0, d_d, 2'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_fg_q <= fg_in;
      s1_bg_q <= bg_in;
      s1_mx_q <= mx_d;
      s1_d_q  <= d_d;
      s1_h0_q <= h0_d;
    end
  end

  // Reciprocal tables, rounded to nearest; zero maps to zero
  assign sd_tab[0] = '0;
  assign hd_tab[0] = '0;
  for (genvar gi = 1; gi < 256; gi++) begin : g_recip
    localparam int unsigned SdVal = (2 * SatNum + gi) / (2 * gi);
    localparam int unsigned HdVal = (2 * HueNum + gi) / (2 * gi);
    assign sd_tab[gi] = SdWidth'(SdVal);
    assign hd_tab[gi] = HdWidth'(HdVal);
  end

  // Stage 2: table lookup
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_fg_q <= s1_fg_q;
      s2_bg_q <= s1_bg_q;
      s2_mx_q <= s1_mx_q;
      s2_d_q  <= s1_d_q;
      s2_h0_q <= s1_h0_q;
      s2_sd_q <= sd_tab[s1_mx_q];
      s2_hd_q <= hd_tab[s1_d_q];
    end
  end

  // Stage 3: scale spread and raw hue by their reciprocals
  assign sprod_d = 28'(s2_d_q) * 28'(s2_sd_q);
  assign hprod_d = 30'(s2_h0_q) * 30'($signed({1'b0, s2_hd_q}));

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_fg_q    <= s2_fg_q;
      s3_bg_q    <= s2_bg_q;
      s3_mx_q    <= s2_mx_q;
      s3_sprod_q <= sprod_d;
      s3_hprod_q <= hprod_d;
    end
  end

  // Stage 4: round, wrap hue, compare bands and pick the pixel
  always_comb begin
    s_round = s3_sprod_q + 28'd2048;
    sat_val = s_round[27:FracBits];
    h_round = s3_hprod_q + 30'sd2048;
    h_shift = h_round >>> FracBits;
    h_wrap  = h_shift[29] ? h_shift + 30'(HueWrap) : h_shift;
    hue_val = h_wrap[8:0];
    hit_d   = (hue_val > {1'b0, hue_low_q}) && (hue_val <= {1'b0, hue_high_q})
           && (sat_val > {8'b0, sat_low_q}) && (sat_val <= {8'b0, sat_high_q})
           && (s3_mx_q > val_low_q) && (s3_mx_q <= val_high_q);
    out_pix_d = hit_d ? s3_bg_q : s3_fg_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pix_q <= out_pix_d;
      key_hit_q <= hit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_blue_o  = out_pix_q.blue;
  assign out_green_o = out_pix_q.green;
  assign out_red_o   = out_pix_q.red;
  assign key_hit_o   = key_hit_q;

`ifndef SYNTHESIS
  // A pixel leaving the multiply stage reaches the output on the next advance
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && advance |=> out_valid_o)
    else $error("multiply stage result not delivered");

  // Wrapped hue stays in the halved-degree range
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (!h_wrap[29] && h_wrap < 30'(HueWrap)))
    else $error("hue out of range");

  // A keyed pixel implies every band is non-empty
  a_band_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_hit_o |->
      (hue_low_q < hue_high_q) && (sat_low_q < sat_high_q) && (val_low_q < val_high_q))
    else $error("key hit with an empty band");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for hsv_chroma_key_compositor: streams foreground/background pixel
// pairs through the valid/ready pipe under several band settings and handshake loads.
// Depends on hck_pkg and the compositor RTL; predicts the HSV key decision locally.
module tb_top;
  import hck_pkg::*;

  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PhaseItems  = 120;

  // Indexes past the band list; writes there must not land anywhere
  localparam logic [2:0] CfgIdxSpareA = 3'd6;
  localparam logic [2:0] CfgIdxSpareB = 3'd7;

  // HSV fixed point: 12 fractional bits, reciprocal numerators
  localparam int FracShift   = 12;
  localparam int RoundHalf   = 2048;
  localparam int SatRecipNum = 255 << 12;
  localparam int HueRecipNum = 180 << 12;
  localparam int HueWrapDeg  = 180;

  typedef logic [5:0][7:0] band_set_t;

  typedef struct packed {
    pixel_t px;
    logic   hit;
  } comp_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_idx_i   = CFG_HUE_LOW;
  logic [7:0] cfg_data_i  = 8'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] fg_blue_i   = 8'd0;
  logic [7:0] fg_green_i  = 8'd0;
  logic [7:0] fg_red_i    = 8'd0;
  logic [7:0] bg_blue_i   = 8'd0;
  logic [7:0] bg_green_i  = 8'd0;
  logic [7:0] bg_red_i    = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_blue_o;
  logic [7:0] out_green_o;
  logic [7:0] out_red_o;
  logic       key_hit_o;

  // Local copy of the six band registers
  logic [7:0] band_cfg [6];

  comp_result_t composite_q [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fail_count    = 0;
  int report_count  = 0;
  int pixels_in     = 0;
  int pixels_out    = 0;
  int keyed_out     = 0;
  int band_sets     = 0;
  int idle_cycles   = 0;

  hsv_chroma_key_compositor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .fg_blue_i   (fg_blue_i),
    .fg_green_i  (fg_green_i),
    .fg_red_i    (fg_red_i),
    .bg_blue_i   (bg_blue_i),
    .bg_green_i  (bg_green_i),
    .bg_red_i    (bg_red_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_blue_o  (out_blue_o),
    .out_green_o (out_green_o),
    .out_red_o   (out_red_o),
    .key_hit_o   (key_hit_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Randomly stall the output side
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic pixel_t mk_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    pixel_t p;
    p.blue  = b;
    p.green = g;
    p.red   = r;
    return p;
  endfunction

  function automatic logic [7:0] rand_byte(int unsigned lo, int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic in_band(int x, logic [7:0] lo, logic [7:0] hi);
    return (x > int'(lo)) && (x <= int'(hi));
  endfunction

  // Convert the foreground to 8-bit HSV, key it against the bands, pick the pixel
  function automatic comp_result_t key_composite(pixel_t fg, pixel_t bg);
    int b, g, r, mx, mn, d, h0, hue, sat, sat_recip, hue_recip;
    comp_result_t res;
    b  = int'(fg.blue);
    g  = int'(fg.green);
    r  = int'(fg.red);
    mx = (g > b) ? g : b;
    mx = (r > mx) ? r : mx;
    mn = (g < b) ? g : b;
    mn = (r < mn) ? r : mn;
    d  = mx - mn;
    sat_recip = (mx == 0) ? 0 : (2 * SatRecipNum + mx) / (2 * mx);
    sat = (d * sat_recip + RoundHalf) >>> FracShift;
    // Red wins ties with green, green wins ties with blue
    if (mx == r) h0 = g - b;
    else if (mx == g) h0 = b - r + 2 * d;
    else h0 = r - g + 4 * d;
    hue_recip = (d == 0) ? 0 : (2 * HueRecipNum + 6 * d) / (12 * d);
    hue = (h0 * hue_recip + RoundHalf) >>> FracShift;
    if (hue < 0) hue += HueWrapDeg;
    res.hit = in_band(hue, band_cfg[CFG_HUE_LOW], band_cfg[CFG_HUE_HIGH]) &&
              in_band(sat, band_cfg[CFG_SAT_LOW], band_cfg[CFG_SAT_HIGH]) &&
              in_band(mx,  band_cfg[CFG_VAL_LOW], band_cfg[CFG_VAL_HIGH]);
    res.px  = res.hit ? bg : fg;
    return res;
  endfunction

  // Predict on every input transfer, check every output transfer, watch for a hang
  always @(posedge clk_i) begin
    comp_result_t exp_res;
    comp_result_t got;
    logic moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        exp_res = key_composite(mk_pixel(fg_blue_i, fg_green_i, fg_red_i),
                                mk_pixel(bg_blue_i, bg_green_i, bg_red_i));
        composite_q.insert(composite_q.size(), exp_res);
        pixels_in++;
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved     = 1'b1;
        got.px    = mk_pixel(out_blue_o, out_green_o, out_red_o);
        got.hit   = key_hit_o;
        pixels_out++;
        keyed_out += int'(key_hit_o);
        if (composite_q.size() == 0) begin
          fail_count++;
          if (report_count < MaxReports)
            $display("%0t: unexpected output b=%0d g=%0d r=%0d key=%0b", $realtime,
                     got.px.blue, got.px.green, got.px.red, got.hit);
          report_count++;
        end else begin
          exp_res = composite_q.pop_front();
          if (got.px.blue != exp_res.px.blue || got.px.green != exp_res.px.green ||
              got.px.red != exp_res.px.red || got.hit != exp_res.hit) begin
            fail_count++;
            if (report_count < MaxReports)
              $display("%0t: mismatch exp b=%0d g=%0d r=%0d key=%0b got b=%0d g=%0d r=%0d key=%0b",
                       $realtime, exp_res.px.blue, exp_res.px.green, exp_res.px.red,
                       exp_res.hit, got.px.blue, got.px.green, got.px.red, got.hit);
            report_count++;
          end
        end
      end
    end
    if (moved) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: %0d cycles without a transfer, %0d results pending",
                 idle_cycles, composite_q.size());
        $display("[hsv_chroma_key_compositor] ERROR");
        $finish;
      end
    end
  end

  // Present one pixel pair after a random gap and hold it until the transfer
  task automatic send_pixel(input pixel_t fg, input pixel_t bg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    fg_blue_i  <= fg.blue;
    fg_green_i <= fg.green;
    fg_red_i   <= fg.red;
    bg_blue_i  <= bg.blue;
    bg_green_i <= bg.green;
    bg_red_i   <= bg.red;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and let every outstanding pixel come out
  task automatic wait_pipe_empty();
    in_valid_i <= 1'b0;
    while (composite_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic band_set_t make_bands(logic [7:0] hl, logic [7:0] hh, logic [7:0] sl,
                                           logic [7:0] sh, logic [7:0] vl, logic [7:0] vh);
    band_set_t bs;
    bs[CFG_HUE_LOW]  = hl;
    bs[CFG_HUE_HIGH] = hh;
    bs[CFG_SAT_LOW]  = sl;
    bs[CFG_SAT_HIGH] = sh;
    bs[CFG_VAL_LOW]  = vl;
    bs[CFG_VAL_HIGH] = vh;
    return bs;
  endfunction

  // Write all six band registers back to back; only call with the pipe empty
  task automatic program_bands(input band_set_t bs);
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= bs[i];
      @(posedge clk_i);
      band_cfg[i] = bs[i];
    end
    cfg_we_i <= 1'b0;
    band_sets++;
  endtask

  function automatic pixel_t rand_fg();
    int unsigned pick;
    logic [7:0] lvl;
    pixel_t p;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // green-screen-like: green dominant, other channels at or below it
      p.green = rand_byte(40, 255);
      p.blue  = rand_byte(0, p.green);
      p.red   = rand_byte(0, p.green);
    end else if (pick < 55) begin
      lvl = rand_byte(0, 255);
      p   = mk_pixel(lvl, lvl, lvl);
    end else begin
      p = mk_pixel(rand_byte(0, 255), rand_byte(0, 255), rand_byte(0, 255));
    end
    return p;
  endfunction

  function automatic pixel_t rand_bg();
    return mk_pixel(rand_byte(0, 255), rand_byte(0, 255), rand_byte(0, 255));
  endfunction

  // A handful of pixels that land on either side of typical bands
  task automatic probe_bands();
    send_pixel(mk_pixel(8'd85, 8'd255, 8'd0), mk_pixel(8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd0), mk_pixel(8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'd255, 8'd255, 8'd255), rand_bg());
    send_pixel(mk_pixel(8'd40, 8'd180, 8'd20), rand_bg());
    send_pixel(rand_fg(), rand_bg());
  endtask

  task automatic apply_and_probe(input band_set_t bs);
    wait_pipe_empty();
    program_bands(bs);
    probe_bands();
  endtask

  // Reset bands, no idling: primaries, grays, hue boundaries and the hue wrap
  task automatic test_reset_bands_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd0), mk_pixel(8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(8'd255, 8'd255, 8'd255), mk_pixel(8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'd128, 8'd128, 8'd128), mk_pixel(8'hA5, 8'h5A, 8'hA5));
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd255), mk_pixel(8'h5A, 8'hA5, 8'h5A));
    send_pixel(mk_pixel(8'd0, 8'd255, 8'd0), mk_pixel(8'hFF, 8'h00, 8'hFF));
    send_pixel(mk_pixel(8'd255, 8'd0, 8'd0), mk_pixel(8'h00, 8'hFF, 8'h00));
    // equal maxima: yellow, cyan, magenta
    send_pixel(mk_pixel(8'd0, 8'd255, 8'd255), rand_bg());
    send_pixel(mk_pixel(8'd255, 8'd255, 8'd0), rand_bg());
    send_pixel(mk_pixel(8'd255, 8'd0, 8'd255), rand_bg());
    // hue right at the lower bound, right at the upper bound, and inside
    send_pixel(mk_pixel(8'd43, 8'd255, 8'd0), mk_pixel(8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(8'd128, 8'd255, 8'd0), mk_pixel(8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'd85, 8'd255, 8'd0), mk_pixel(8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(8'd85, 8'd255, 8'd0), mk_pixel(8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'd22, 8'd66, 8'd0), mk_pixel(8'h12, 8'h34, 8'h56));
    // red maximum with blue above green: negative raw hue wraps
    send_pixel(mk_pixel(8'd100, 8'd0, 8'd255), rand_bg());
    send_pixel(mk_pixel(8'd1, 8'd0, 8'd1), rand_bg());
    // dimmest pixels, then a near-white one
    send_pixel(mk_pixel(8'd0, 8'd1, 8'd0), rand_bg());
    send_pixel(mk_pixel(8'd1, 8'd0, 8'd0), rand_bg());
    send_pixel(mk_pixel(8'd254, 8'd255, 8'd254), rand_bg());
  endtask

  // Extreme and degenerate band settings
  task automatic test_band_extremes();
    send_idle_pct = 38;
    stall_pct     = 38;
    apply_and_probe(make_bands(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255));
    apply_and_probe(make_bands(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
    apply_and_probe(make_bands(8'd179, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255));
    apply_and_probe(make_bands(8'd70, 8'd70, 8'd100, 8'd100, 8'd200, 8'd200));
    apply_and_probe(make_bands(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    apply_and_probe(make_bands(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
  endtask

  // Writes beyond the band list must leave every band untouched
  task automatic test_spare_index_writes();
    send_idle_pct = 0;
    stall_pct     = 0;
    wait_pipe_empty();
    program_bands(make_bands(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255));
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgIdxSpareA;
    cfg_data_i <= 8'hFF;
    @(posedge clk_i);
    cfg_idx_i  <= CfgIdxSpareB;
    cfg_data_i <= 8'h00;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    probe_bands();
  endtask

  // Random pixels under four handshake loads, each with a green band and a random band
  task automatic test_random_traffic();
    logic [7:0] lo_a, hi_a, lo_b, hi_b, lo_c, hi_c;
    band_set_t bs;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      for (int kind = 0; kind < 2; kind++) begin
        if (kind == 0) begin
          lo_a = rand_byte(40, 70);
          bs = make_bands(lo_a, lo_a + rand_byte(5, 40), rand_byte(0, 100),
                          rand_byte(150, 255), rand_byte(0, 80), rand_byte(180, 255));
        end else begin
          lo_a = rand_byte(0, 255); hi_a = rand_byte(0, 255);
          lo_b = rand_byte(0, 255); hi_b = rand_byte(0, 255);
          lo_c = rand_byte(0, 255); hi_c = rand_byte(0, 255);
          // mostly ordered pairs, sometimes left reversed
          if ($urandom_range(3) != 0) begin
            if (lo_a > hi_a) {lo_a, hi_a} = {hi_a, lo_a};
            if (lo_b > hi_b) {lo_b, hi_b} = {hi_b, lo_b};
            if (lo_c > hi_c) {lo_c, hi_c} = {hi_c, lo_c};
          end
          bs = make_bands(lo_a, hi_a, lo_b, hi_b, lo_c, hi_c);
        end
        wait_pipe_empty();
        program_bands(bs);
        for (int n = 0; n < PhaseItems; n++) send_pixel(rand_fg(), rand_bg());
      end
    end
  endtask

  initial begin
    band_cfg[CFG_HUE_LOW]  = HueLowRst;
    band_cfg[CFG_HUE_HIGH] = HueHighRst;
    band_cfg[CFG_SAT_LOW]  = SatLowRst;
    band_cfg[CFG_SAT_HIGH] = SatHighRst;
    band_cfg[CFG_VAL_LOW]  = ValLowRst;
    band_cfg[CFG_VAL_HIGH] = ValHighRst;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_bands_directed();
    test_band_extremes();
    test_spare_index_writes();
    test_random_traffic();
    wait_pipe_empty();

    $display("checked %0d of %0d pixels, %0d keyed, over %0d band settings",
             pixels_out, pixels_in, keyed_out, band_sets + 1);
    $display("loads: free-running, sparse sender, stalled receiver, mixed; %0d failures",
             fail_count);
    if (fail_count == 0) begin
      $display("[hsv_chroma_key_compositor] OK");
    end else begin
      $display("[hsv_chroma_key_compositor] ERROR");
    end
    $finish;
  end

endmodule
